// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst
`define CHK_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on clk, off during rst
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/hth_pkg.sv =====
// Types, codes and constants of the hit-time histogrammer
package hth_pkg;

  // parameter defaults
  localparam int NUM_CHANNELS_DEF = 1024;
  localparam int NUM_BINS_DEF     = 1024;
  localparam int COUNT_WIDTH_DEF  = 16;

  // field and port widths
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int SENSOR_W   = 16;
  localparam int TIME_W     = 16;
  localparam int QCH_W      = 10;
  localparam int MAPCH_W    = 16;
  localparam int TOTAL_W    = 26;
  localparam int S_TDATA_W  = 80;
  localparam int M_TDATA_W  = 48;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 12;
  localparam int CHAN_W     = 25;
  localparam int THR_W      = 25;
  localparam int DIV_W      = 16;
  localparam int DIV_CNT_W  = 5;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // commands
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_HIT   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_WINDOW  = 2'd1,
    ST_RANGE   = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INNER_PER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_HOOPS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_CHPH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_HOOPS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_VER     = 3'd5;

  // outer numbering rules
  localparam logic [2:0] MAP_V1 = 3'd1;
  localparam logic [2:0] MAP_V2 = 3'd2;
  localparam logic [2:0] MAP_V3 = 3'd3;
  localparam logic [2:0] MAP_V4 = 3'd4;

  // outer mapping constants
  localparam int OUTER_BASE_CH  = 900;
  localparam int ENDCAP_A       = 1000;
  localparam int ENDCAP_B       = 1001;
  localparam int SPAN_SHORT     = 1000;
  localparam int END_SHORT      = 1100;
  localparam int SPAN_LONG      = 5000;
  localparam int END_LONG       = 5100;
  localparam int DIV_HUNDRED    = 100;
  localparam int DIV_TEN        = 10;
  localparam int DIV_FIFTY      = 50;
  localparam int ENDCAP_SENSORS = 2 * 100;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HSEL,
    S_DIV1,
    S_LD2,
    S_DIV2,
    S_LD3,
    S_DIV3,
    S_MAP,
    S_CHECK,
    S_RD,
    S_RMW,
    S_QSET,
    S_QRD,
    S_QDRAIN,
    S_OUT
  } st_t;

endpackage

// ===== src/hth_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module hth_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hit_time_histogrammer_top.sv =====
// Hit-time histogrammer: sensor mapping sequencer, shared divider, counter store
// Sequence: a clear writes zero to every counter address; a hit runs sensor select, the
//   divider passes, map, check, read and update, and skips the read and update when it is
//   not counted; a query reads each bin of its window; DEPTH = NUM_CHANNELS * NUM_BINS.
// Throughput: one item at a time; the 16-step shared divider and the single
//   counter RAM port set the per-item time. Reset: synchronous rst loads register
//   defaults and runs a clearing pass over the counter RAM with s_tready low; config writes are still taken.
`include "assert_macros.svh"

module hit_time_histogrammer_top #(
  parameter int NUM_CHANNELS = hth_pkg::NUM_CHANNELS_DEF,
  parameter int NUM_BINS     = hth_pkg::NUM_BINS_DEF,
  parameter int COUNT_WIDTH  = hth_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hth_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hth_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // sensor_id, time_bin, query_channel, window_start, window_end, zero pad
  input  logic [hth_pkg::S_TDATA_W-1:0]   s_tdata,
  // cmd
  input  logic [hth_pkg::CMD_W-1:0]       s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // mapped_channel, window_total, zero pad
  output logic [hth_pkg::M_TDATA_W-1:0]   m_tdata,
  // status
  output logic [hth_pkg::STATUS_W-1:0]    m_tuser
);
  import hth_pkg::*;

  localparam int DEPTH  = NUM_CHANNELS * NUM_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIN_W  = $clog2(NUM_BINS);
  localparam logic [ADDR_W-1:0]      NB_A      = ADDR_W'(NUM_BINS);
  localparam logic [ADDR_W-1:0]      ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = '1;

  // configuration registers
  logic [11:0] cfg_isph;
  logic [9:0]  cfg_ih;
  logic [7:0]  cfg_icph;
  logic [9:0]  cfg_osph;
  logic [9:0]  cfg_oh;
  logic [2:0]  cfg_ver;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_isph <= 12'd100;
      cfg_ih   <= 10'd9;
      cfg_icph <= 8'd1;
      cfg_osph <= 10'd100;
      cfg_oh   <= 10'd12;
      cfg_ver  <= MAP_V2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INNER_PER:   cfg_isph <= cfg_data;
        REG_INNER_HOOPS: cfg_ih   <= cfg_data[9:0];
        REG_INNER_CHPH:  cfg_icph <= cfg_data[7:0];
        REG_OUTER_PER:   cfg_osph <= cfg_data[9:0];
        REG_OUTER_HOOPS: cfg_oh   <= cfg_data[9:0];
        REG_MAP_VER:     cfg_ver  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // derived sizes, one multiply each, registered
  logic [21:0]        isens;
  logic signed [22:0] osens;
  logic [18:0]        live;
  logic [21:0]        isens_p;
  logic signed [10:0] oh_m2;
  logic signed [10:0] osph_s;
  logic signed [21:0] oprod;
  logic [17:0]        iprod;

  assign isens_p = cfg_isph * cfg_ih;
  assign oh_m2   = $signed({1'b0, cfg_oh}) - 11'sd2;
  assign osph_s  = $signed({1'b0, cfg_osph});
  assign oprod   = osph_s * oh_m2;
  assign iprod   = cfg_icph * cfg_ih;

  always_ff @(posedge clk) begin
    isens <= isens_p;
    osens <= {oprod[21], oprod} + 23'(ENDCAP_SENSORS);
    live  <= {1'b0, iprod} + {9'b0, cfg_oh};
  end

  // state and item registers
  st_t state, state_next;
  logic                    it_act;
  logic [SENSOR_W-1:0]     it_sens;
  logic [TIME_W-1:0]       it_time;
  logic [QCH_W-1:0]        it_qch;
  logic [TIME_W-1:0]       it_ws;
  logic [TIME_W-1:0]       it_we;
  logic                    is_inner;
  logic [DIV_W-1:0]        hoop;
  logic [DIV_W-1:0]        rem1;
  logic [CHAN_W-1:0]       chan;
  logic [ADDR_W-1:0]       addr;
  logic [ADDR_W-1:0]       base;
  logic [ADDR_W-1:0]       clr_addr;
  logic [BIN_W-1:0]        q_cur;
  logic [BIN_W-1:0]        q_end;
  logic                    rd_pend;
  status_t                 res_status;
  logic [MAPCH_W-1:0]      res_chan;
  logic [TOTAL_W-1:0]      res_total;
  status_t                 m_status;
  logic [MAPCH_W-1:0]      m_chan;
  logic [TOTAL_W-1:0]      m_total;

  // shared restoring divider
  logic [DIV_W-1:0]     dv_rem, dv_quo, dv_den;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic [DIV_W:0]       dv_sh, dv_diff;
  logic                 dv_ge;
  logic                 dv_last;

  assign dv_sh   = {dv_rem, dv_quo[DIV_W-1]};
  assign dv_diff = dv_sh - {1'b0, dv_den};
  assign dv_ge   = dv_sh >= {1'b0, dv_den};
  assign dv_last = dv_cnt == DIV_CNT_W'(1);

  // memory
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [COUNT_WIDTH-1:0] mem_wdata, mem_rdata, cnt_inc;

  hth_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign cnt_inc = (mem_rdata == CNT_MAX) ? mem_rdata : mem_rdata + 1'b1;

  // sensor thresholds
  logic signed [THR_W-1:0] s_ext, isens_s, thr_s1, thr_e1, thr_s3, thr_e3, thr_4a, thr_4b;
  logic signed [THR_W-1:0] osens_s, osph_t;
  logic                    inner_now;
  logic [DIV_W-1:0]        s_off;

  assign s_ext     = $signed({9'b0, it_sens});
  assign isens_s   = $signed({3'b0, isens});
  assign osens_s   = $signed({{2{osens[22]}}, osens});
  assign osph_t    = $signed({15'b0, cfg_osph});
  assign thr_s1    = isens_s + THR_W'(SPAN_SHORT);
  assign thr_e1    = isens_s + THR_W'(END_SHORT);
  assign thr_s3    = isens_s + THR_W'(SPAN_LONG);
  assign thr_e3    = isens_s + THR_W'(END_LONG);
  assign thr_4a    = isens_s + osens_s - (osph_t <<< 1);
  assign thr_4b    = isens_s + osens_s - osph_t;
  assign inner_now = s_ext < isens_s;
  assign s_off     = it_sens - isens[DIV_W-1:0];

  // channel mapping result
  logic [23:0]       hprod;
  logic [CHAN_W-1:0] chan_map;

  assign hprod = hoop * cfg_icph;

  always_comb begin
    chan_map = '0;
    if (is_inner) begin
      chan_map = {1'b0, hprod} + {9'b0, dv_quo};
    end else begin
      case (cfg_ver)
        MAP_V1: chan_map = (s_ext < thr_s1) ? CHAN_W'(OUTER_BASE_CH) + {9'b0, dv_rem} :
                           (s_ext < thr_e1) ? CHAN_W'(ENDCAP_A) : CHAN_W'(ENDCAP_B);
        MAP_V2: chan_map = (s_ext < thr_s1) ? CHAN_W'(OUTER_BASE_CH) + {9'b0, dv_quo} :
                           (s_ext < thr_e1) ? CHAN_W'(ENDCAP_A) : CHAN_W'(ENDCAP_B);
        MAP_V3: chan_map = (s_ext < thr_s3) ? CHAN_W'(OUTER_BASE_CH) + {9'b0, dv_quo} :
                           (s_ext < thr_e3) ? CHAN_W'(ENDCAP_A) : CHAN_W'(ENDCAP_B);
        MAP_V4: chan_map = (s_ext < thr_4a) ? {9'b0, dv_quo} :
                           (s_ext < thr_4b) ? CHAN_W'(ENDCAP_A) : CHAN_W'(ENDCAP_B);
        default: chan_map = '0;
      endcase
    end
  end

  // checks
  logic chan_ok, qch_ok, time_bad, q_empty;
  logic [TIME_W-1:0] ws_c, we_c;

  assign chan_ok  = (chan < {6'b0, live}) && (chan < CHAN_W'(NUM_CHANNELS));
  assign qch_ok   = ({9'b0, it_qch} < live) && ({15'b0, it_qch} < CHAN_W'(NUM_CHANNELS));
  assign time_bad = it_time[TIME_W-1] || (it_time >= TIME_W'(NUM_BINS));
  assign ws_c     = it_ws[TIME_W-1] ? '0 : it_ws;
  assign we_c     = (it_we >= TIME_W'(NUM_BINS)) ? TIME_W'(NUM_BINS - 1) : it_we;
  assign q_empty  = it_we[TIME_W-1] || (ws_c > we_c);

  // window sum step, saturating
  logic [32:0] sum_w;
  assign sum_w = {7'b0, res_total} + 33'(mem_rdata);

  logic in_fire, out_load;
  assign in_fire  = s_tvalid && s_tready;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_addr == ADDR_LAST) state_next = it_act ? S_OUT : S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_t'(s_tuser))
            CMD_CLEAR: state_next = S_CLEAR;
            CMD_HIT:   state_next = S_HSEL;
            CMD_QUERY: state_next = S_QSET;
            default:   state_next = S_OUT;
          endcase
        end
      end
      S_HSEL: begin
        if (inner_now || cfg_ver == MAP_V1 || cfg_ver == MAP_V2 ||
            cfg_ver == MAP_V3 || cfg_ver == MAP_V4) begin
          state_next = S_DIV1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DIV1:   if (dv_last) state_next = is_inner ? S_LD2 : S_MAP;
      S_LD2:    state_next = S_DIV2;
      S_DIV2:   if (dv_last) state_next = S_LD3;
      S_LD3:    state_next = S_DIV3;
      S_DIV3:   if (dv_last) state_next = S_MAP;
      S_MAP:    state_next = S_CHECK;
      S_CHECK:  state_next = (!time_bad && chan_ok) ? S_RD : S_OUT;
      S_RD:     state_next = S_RMW;
      S_RMW:    state_next = S_OUT;
      S_QSET:   state_next = (qch_ok && !q_empty) ? S_QRD : S_OUT;
      S_QRD:    if (q_cur == q_end) state_next = S_QDRAIN;
      S_QDRAIN: state_next = S_OUT;
      S_OUT:    if (!m_tvalid || m_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr;
    mem_wdata = cnt_inc;
    mem_raddr = addr;
    unique case (state)
      S_IDLE:  s_tready = 1'b1;
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_RMW:   mem_we = 1'b1;
      S_QRD:   mem_raddr = base + ADDR_W'(q_cur);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      it_act   <= 1'b0;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_QRD);
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      if (in_fire) begin
        it_act <= 1'b1;
      end else if (out_load) begin
        it_act <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        it_sens   <= s_tdata[15:0];
        it_time   <= s_tdata[31:16];
        it_qch    <= s_tdata[41:32];
        it_ws     <= s_tdata[57:42];
        it_we     <= s_tdata[73:58];
        res_chan  <= '0;
        res_total <= '0;
        res_status <= (cmd_t'(s_tuser) == CMD_CLEAR) ? ST_CLEARED : ST_OK;
      end
      S_HSEL: begin
        is_inner <= inner_now;
        dv_rem   <= '0;
        dv_cnt   <= DIV_CNT_W'(DIV_W);
        if (inner_now) begin
          dv_quo <= it_sens;
          dv_den <= {4'b0, cfg_isph};
        end else begin
          case (cfg_ver)
            MAP_V2: begin
              dv_quo <= s_off;
              dv_den <= DIV_W'(DIV_TEN);
            end
            MAP_V3: begin
              dv_quo <= s_off;
              dv_den <= DIV_W'(DIV_FIFTY);
            end
            default: begin
              dv_quo <= it_sens;
              dv_den <= DIV_W'(DIV_HUNDRED);
            end
          endcase
          if (!(cfg_ver == MAP_V1 || cfg_ver == MAP_V2 ||
                cfg_ver == MAP_V3 || cfg_ver == MAP_V4)) begin
            res_status <= ST_RANGE;
          end
        end
      end
      S_DIV1, S_DIV2, S_DIV3: begin
        dv_rem <= dv_ge ? dv_diff[DIV_W-1:0] : dv_sh[DIV_W-1:0];
        dv_quo <= {dv_quo[DIV_W-2:0], dv_ge};
        dv_cnt <= dv_cnt - 1'b1;
      end
      S_LD2: begin
        hoop   <= dv_quo;
        rem1   <= dv_rem;
        dv_rem <= '0;
        dv_quo <= {4'b0, cfg_isph};
        dv_den <= {8'b0, cfg_icph};
        dv_cnt <= DIV_CNT_W'(DIV_W);
      end
      S_LD3: begin
        // a zero sub-channel width counts as one
        dv_rem <= '0;
        dv_quo <= rem1;
        dv_den <= (cfg_icph == '0 || dv_quo == '0) ? DIV_W'(1) : dv_quo;
        dv_cnt <= DIV_CNT_W'(DIV_W);
      end
      S_MAP: chan <= chan_map;
      S_CHECK: begin
        res_chan <= chan[MAPCH_W-1:0];
        addr     <= ADDR_W'(chan) * NB_A + ADDR_W'(it_time);
        if (time_bad) begin
          res_status <= ST_WINDOW;
        end else if (!chan_ok) begin
          res_status <= ST_RANGE;
        end
      end
      S_QSET: begin
        res_chan <= {6'b0, it_qch};
        base     <= ADDR_W'(it_qch) * NB_A;
        q_cur    <= ws_c[BIN_W-1:0];
        q_end    <= we_c[BIN_W-1:0];
        if (!qch_ok) begin
          res_status <= ST_RANGE;
        end
      end
      S_QRD, S_QDRAIN: begin
        if (state == S_QRD) begin
          q_cur <= q_cur + 1'b1;
        end
        if (rd_pend) begin
          res_total <= (sum_w > {7'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_w[TOTAL_W-1:0];
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_status <= res_status;
          m_chan   <= res_chan;
          m_total  <= res_total;
        end
      end
      default: ;
    endcase
  end

  assign m_tuser = m_status;
  assign m_tdata = {6'b0, m_total, m_chan};

  // checks on the sequencer
  `CHK_IMPLY(a_we_src, mem_we, (state == S_CLEAR) || (state == S_RMW))
  `CHK_IMPLY(a_cur_end, state == S_QRD, q_cur <= q_end)
  `CHK_NEXT(a_accept_leaves, s_tvalid && s_tready, state != S_IDLE)
  `CHK_NEXT(a_out_hold, (state == S_OUT) && m_tvalid && !m_tready, state == S_OUT)

endmodule

// ===== verif/tb_hit_time_histogrammer_top.sv =====
// Self-checking testbench of the hit-time histogrammer top level
`timescale 1ns / 100ps

module tb_hit_time_histogrammer_top;
  import hth_pkg::*;

  localparam int NBINS = NUM_BINS_DEF;
  localparam int NCH = NUM_CHANNELS_DEF;
  localparam longint CNT_MAX = (64'd1 << COUNT_WIDTH_DEF) - 1;
  localparam longint CYCLE_LIMIT = 12_000_000;

  typedef struct {
    cmd_t             cmd;
    logic [15:0]      sensor;
    logic signed [15:0] tbin;
    logic [9:0]       qchan;
    logic signed [15:0] wstart;
    logic signed [15:0] wend;
  } hist_req_t;

  typedef struct {
    status_t     status;
    logic [15:0] chan;
    logic [25:0] total;
  } hist_resp_t;

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic s_tvalid, s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [CMD_W-1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  hit_time_histogrammer_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // predictor state: mirrored registers and sparse bin counts
  longint in_per, in_hoops, in_chph, out_per, out_hoops, map_ver;
  longint bin_cnt[longint];
  hist_resp_t resp_q[$];

  int err_cnt = 0;
  int hit_cnt = 0, query_cnt = 0, resp_cnt = 0;
  longint cycles = 0;
  bit no_idle = 0;
  int rx_stall = 0;
  int rx_seen = 0;

  // clock
  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit chan_live(longint c);
    return c >= 0 && c < in_chph * in_hoops + out_hoops && c < NCH;
  endfunction

  // sensor to readout channel; returns 0 on unknown outer numbering rule
  function automatic bit sensor_to_chan(longint s, output longint c);
    longint isens, osens, dv;
    isens = in_per * in_hoops;
    osens = out_per * (out_hoops - 2) + 2 * 100;
    c = 0;
    if (s < isens) begin
      dv = (in_chph != 0) ? in_per / in_chph : 0;
      if (dv == 0) dv = 1;
      c = (s / in_per) * in_chph + (s % in_per) / dv;
      return 1;
    end
    case (map_ver)
      1: c = s < isens + 1000 ? 900 + s % 100 : (s < isens + 1100 ? 1000 : 1001);
      2: c = s < isens + 1000 ? 900 + (s - isens) / 10 : (s < isens + 1100 ? 1000 : 1001);
      3: c = s < isens + 5000 ? 900 + (s - isens) / 50 : (s < isens + 5100 ? 1000 : 1001);
      4: begin
        if (s < isens + osens - 2 * out_per) c = s / 100;
        else if (s < isens + osens - out_per) c = 1000;
        else c = 1001;
      end
      default: return 0;
    endcase
    return 1;
  endfunction

  // expected response of one accepted request; updates the bin counts
  function automatic hist_resp_t histogram_step(hist_req_t r);
    hist_resp_t e;
    longint c, t, a, b, sum, key;
    e.status = ST_OK; e.chan = '0; e.total = '0;
    case (r.cmd)
      CMD_CLEAR: begin
        bin_cnt.delete();
        e.status = ST_CLEARED;
      end
      CMD_HIT: begin
        t = r.tbin;
        if (!sensor_to_chan(longint'(r.sensor), c)) e.status = ST_RANGE;
        else begin
          e.chan = c[15:0];
          if (t < 0 || t >= NBINS) e.status = ST_WINDOW;
          else if (!chan_live(c)) e.status = ST_RANGE;
          else begin
            key = c * NBINS + t;
            if (!bin_cnt.exists(key)) bin_cnt[key] = 0;
            if (bin_cnt[key] < CNT_MAX) bin_cnt[key]++;
          end
        end
      end
      CMD_QUERY: begin
        c = r.qchan;
        e.chan = {6'b0, r.qchan};
        if (!chan_live(c)) e.status = ST_RANGE;
        else begin
          a = r.wstart; b = r.wend; sum = 0;
          if (a < 0) a = 0;
          if (b >= NBINS) b = NBINS - 1;
          for (longint i = a; i <= b; i++)
            if (bin_cnt.exists(c * NBINS + i)) sum += bin_cnt[c * NBINS + i];
          e.total = sum > 64'h3FFFFFF ? 26'h3FFFFFF : sum[25:0];
        end
      end
      default: ;
    endcase
    return e;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d (response %0d)", what, got, want, resp_cnt);
    err_cnt++;
  endtask

  // register write, only while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = val[CFG_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_INNER_PER:   in_per = val & 12'hFFF;
      REG_INNER_HOOPS: in_hoops = val & 10'h3FF;
      REG_INNER_CHPH:  in_chph = val & 8'hFF;
      REG_OUTER_PER:   out_per = val & 10'h3FF;
      REG_OUTER_HOOPS: out_hoops = val & 10'h3FF;
      REG_MAP_VER:     map_ver = val & 3'h7;
      default: ;
    endcase
  endtask

  task automatic set_geometry(int ip, int ih, int ic, int op, int oh, int mv);
    write_reg(REG_INNER_PER, ip);
    write_reg(REG_INNER_HOOPS, ih);
    write_reg(REG_INNER_CHPH, ic);
    write_reg(REG_OUTER_PER, op);
    write_reg(REG_OUTER_HOOPS, oh);
    write_reg(REG_MAP_VER, mv);
  endtask

  // send one request beat and log its expected response
  task automatic send_req(hist_req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = r.cmd;
    s_tdata = {6'b0, r.wend, r.wstart, r.qchan, r.tbin, r.sensor};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    resp_q.insert(resp_q.size(), histogram_step(r));
    if (r.cmd == CMD_HIT) hit_cnt++;
    if (r.cmd == CMD_QUERY) query_cnt++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (resp_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic hist_req_t mk(cmd_t c, int s, int t, int q, int a, int b);
    hist_req_t r;
    r.cmd = c; r.sensor = s[15:0]; r.tbin = t[15:0]; r.qchan = q[9:0];
    r.wstart = a[15:0]; r.wend = b[15:0];
    return r;
  endfunction

  // random request shaped after the current geometry
  function automatic hist_req_t rand_req(int pool_s, int pool_t);
    hist_req_t r;
    int k, span, a;
    longint isens;
    isens = in_per * in_hoops;
    r = mk(CMD_HIT, $urandom, $urandom, $urandom, $urandom, $urandom);
    k = $urandom_range(0, 99);
    if (k < 3) r.cmd = CMD_NONE;
    else if (k < 25) begin
      r.cmd = CMD_QUERY;
      if ($urandom_range(0, 9) != 0) begin
        span = $urandom_range(0, 40);
        a = $urandom_range(0, 70) - 5;
        r.wstart = a[15:0];
        r.wend = 16'(a + span);
        if ($urandom_range(0, 1)) begin
          void'(sensor_to_chan(pool_s, isens));
          r.qchan = isens[9:0];
        end else r.qchan = 10'($urandom_range(0, 1023));
      end
    end else begin
      k = $urandom_range(0, 9);
      if (k < 4) r.sensor = 16'(pool_s + $urandom_range(0, 2));
      else if (k < 8) r.sensor = 16'($urandom_range(0, int'(isens) + 2200));
      k = $urandom_range(0, 9);
      if (k < 5) r.tbin = 16'(pool_t + $urandom_range(0, 3));
      else if (k < 9) r.tbin = 16'($urandom_range(0, NBINS - 1));
    end
    return r;
  endfunction

  // response sink with random stalls, a fresh stall after every taken beat
  always @(negedge clk) begin
    if (resp_cnt != rx_seen) begin
      rx_seen = resp_cnt;
      rx_stall = $urandom_range(0, 15);
    end
    if (rx_stall > 0 && !no_idle) begin
      m_tready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else m_tready <= 1'b1;
  end

  // response checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      hist_resp_t e;
      resp_cnt++;
      if (resp_q.size() == 0) begin
        $display("MISMATCH unexpected response beat %0d", resp_cnt);
        err_cnt++;
      end else begin
        e = resp_q.pop_front();
        if (m_tuser !== e.status) report("status", m_tuser, e.status);
        if (m_tdata[15:0] !== e.chan) report("mapped_channel", m_tdata[15:0], e.chan);
        if (m_tdata[41:16] !== e.total) report("window_total", m_tdata[41:16], e.total);
        if (m_tdata[47:42] !== 6'b0) report("pad", m_tdata[47:42], 0);
      end
    end
  end

  // edges, special cases and every command under reset geometry
  task automatic test_directed();
    send_req(mk(CMD_HIT, 0, 0, 0, 0, 0));
    send_req(mk(CMD_HIT, 0, 0, 0, 0, 0));
    send_req(mk(CMD_HIT, 899, 1023, 0, 0, 0));
    send_req(mk(CMD_HIT, 0, -1, 0, 0, 0));
    send_req(mk(CMD_HIT, 0, 1024, 0, 0, 0));
    send_req(mk(CMD_HIT, 0, -32768, 0, 0, 0));
    send_req(mk(CMD_HIT, 0, 32767, 0, 0, 0));
    send_req(mk(CMD_HIT, 900, 5, 0, 0, 0));
    send_req(mk(CMD_HIT, 1899, 5, 0, 0, 0));
    send_req(mk(CMD_HIT, 1900, 5, 0, 0, 0));
    send_req(mk(CMD_HIT, 2000, 5, 0, 0, 0));
    send_req(mk(CMD_HIT, 65535, 7, 0, 0, 0));
    send_req(mk(CMD_QUERY, 0, 0, 0, -32768, 32767));
    send_req(mk(CMD_QUERY, 0, 0, 8, 1023, 1023));
    send_req(mk(CMD_QUERY, 0, 0, 0, 5, 4));
    send_req(mk(CMD_QUERY, 0, 0, 1023, 0, 10));
    send_req(mk(CMD_QUERY, 65535, 65535, 20, 1, 32767));
    send_req(mk(CMD_NONE, 65535, 65535, 1023, 65535, 65535));
    send_req(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
    send_req(mk(CMD_QUERY, 0, 0, 0, 0, 1023));
    drain();
  endtask

  // outer numbering rules 1, 3 and 4, unknown rules and the zero divisor case
  task automatic test_rules();
    int rules[6] = '{1, 3, 4, 0, 5, 7};
    foreach (rules[i]) begin
      write_reg(REG_MAP_VER, rules[i]);
      send_req(mk(CMD_HIT, 950, 3, 0, 0, 0));
      send_req(mk(CMD_HIT, 5950, 3, 0, 0, 0));
      send_req(mk(CMD_HIT, 1950, 3, 0, 0, 0));
      drain();
    end
    // one sensor per hoop split over many channels
    set_geometry(1, 1, 255, 1, 2, 4);
    send_req(mk(CMD_HIT, 0, 9, 0, 0, 0));
    send_req(mk(CMD_HIT, 1, 9, 0, 0, 0));
    send_req(mk(CMD_HIT, 300, 9, 0, 0, 0));
    send_req(mk(CMD_QUERY, 0, 0, 0, 0, 1023));
    drain();
    // largest geometry
    set_geometry(4095, 1023, 255, 1023, 1023, 4);
    send_req(mk(CMD_HIT, 65535, 1, 0, 0, 0));
    send_req(mk(CMD_HIT, 4095 * 3 + 17, 1, 0, 0, 0));
    send_req(mk(CMD_QUERY, 0, 0, 1023, -1, 1023));
    drain();
  endtask

  // random traffic over several geometries
  task automatic test_random();
    int geo[5][6] = '{'{100, 9, 1, 100, 12, 2}, '{64, 4, 8, 40, 30, 1},
                      '{30, 10, 3, 20, 50, 3}, '{12, 6, 4, 30, 20, 4},
                      '{1, 1, 1, 1, 2, 2}};
    int pool_s, pool_t;
    foreach (geo[g]) begin
      set_geometry(geo[g][0], geo[g][1], geo[g][2], geo[g][3], geo[g][4], geo[g][5]);
      no_idle = (g == 2);
      for (int i = 0; i < 280; i++) begin
        if (i % 40 == 0) begin
          pool_s = $urandom_range(0, int'(in_per * in_hoops) + 150);
          pool_t = $urandom_range(0, 60);
        end
        send_req(rand_req(pool_s, pool_t));
      end
      drain();
    end
    no_idle = 0;
  endtask

  initial begin
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    s_tvalid = 1'b0; s_tdata = '0; s_tuser = CMD_NONE;
    in_per = 100; in_hoops = 9; in_chph = 1; out_per = 100; out_hoops = 12; map_ver = 2;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_rules();
    test_random();
    $display("Covered %0d hits and %0d window queries, %0d responses checked,",
             hit_cnt, query_cnt, resp_cnt);
    $display("over all four outer rules, unknown rules and extreme geometries.");
    if (err_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/hth_pkg.sv
src/hth_ram.sv
src/hit_time_histogrammer_top.sv
verif/tb_hit_time_histogrammer_top.sv
